// ----- src/prime_filter_trial_division_macros.svh -----
// ---------------------------------------------------------------------------
// Prime filter assertion macros
// Shared concurrent assertion forms for the prime filter block.
// ---------------------------------------------------------------------------
`ifndef PRIME_FILTER_TRIAL_DIVISION_MACROS_SVH
`define PRIME_FILTER_TRIAL_DIVISION_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prime filter check failed");

// next-cycle implication, disabled in reset
`define PFTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prime filter check failed");

`endif

// ----- src/pftd_pkg.sv -----
// ---------------------------------------------------------------------------
// Prime filter package
// Shared constants and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pftd_pkg;

  localparam int PFTD_VALUE_WIDTH = 32;
  localparam int PFTD_FIRST_DIV   = 2;
  localparam int PFTD_FIRST_SQ    = PFTD_FIRST_DIV * PFTD_FIRST_DIV;
  localparam int PFTD_MIN_PRIME   = 2;

  typedef struct packed {
    logic load;       // capture candidate, reset divisor
    logic start_div;  // clear remainder, load dividend shifter
    logic div_step;   // one restoring division step
    logic next_div;   // advance divisor and its square
    logic load_out;   // copy candidate to output register
  } pftd_cmd_t;

  typedef struct packed {
    logic reject_in;  // negative, zero or one
    logic sq_gt;      // divisor squared exceeds candidate
    logic div_last;   // final division step
    logic rem_zero;   // remainder is zero
  } pftd_status_t;

endpackage

// ----- src/pftd_if.sv -----
// ---------------------------------------------------------------------------
// Prime filter channel interfaces
// Valid/ready channels for candidate and prime result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pftd_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface pftd_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-2:0] prime_value;

  modport source (output valid, output prime_value, input ready);
  modport sink   (input valid, input prime_value, output ready);
endinterface

// ----- src/pftd_ctrl.sv -----
// ---------------------------------------------------------------------------
// Prime filter controller
// Sequences acceptance, trial divisions and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pftd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pftd_pkg::pftd_status_t status,
  output pftd_pkg::pftd_cmd_t    cmd
);
  import pftd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   slot_free;

  assign slot_free = !out_vld_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !status.reject_in) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.sq_gt) begin
          if (slot_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ----- src/pftd_dp.sv -----
// ---------------------------------------------------------------------------
// Prime filter datapath
// Candidate, divisor and running square, bit-serial remainder unit, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pftd_dp #(
  parameter int VALUE_WIDTH = pftd_pkg::PFTD_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] candidate,
  input  pftd_pkg::pftd_cmd_t           cmd,
  output pftd_pkg::pftd_status_t        status,
  output logic        [VALUE_WIDTH-2:0] prime_value
);
  import pftd_pkg::*;

  localparam int N  = VALUE_WIDTH - 1;
  localparam int CW = $clog2(N);

  logic [N-1:0]  v_r, d_r, rem_r, sh_r, out_r;
  logic [N:0]    sq_r;
  logic [CW-1:0] cnt_r;
  logic [N:0]    trial;
  logic [N:0]    diff;
  logic          fits;

  assign trial = {rem_r, sh_r[N-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = (trial >= {1'b0, d_r});

  assign status.reject_in = candidate[VALUE_WIDTH-1] ||
                            (candidate[N-1:0] < N'(PFTD_MIN_PRIME));
  assign status.sq_gt     = (sq_r > {1'b0, v_r});
  assign status.div_last  = (cnt_r == '0);
  assign status.rem_zero  = (rem_r == '0);
  assign prime_value      = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r  <= candidate[N-1:0];
      d_r  <= N'(PFTD_FIRST_DIV);
      sq_r <= (N+1)'(PFTD_FIRST_SQ);
    end
    if (cmd.next_div) begin
      d_r  <= d_r + N'(1);
      sq_r <= sq_r + {d_r, 1'b1};
    end
    if (cmd.start_div) begin
      rem_r <= '0;
      sh_r  <= v_r;
      cnt_r <= CW'(N - 1);
    end
    if (cmd.div_step) begin
      rem_r <= fits ? diff[N-1:0] : trial[N-1:0];
      sh_r  <= {sh_r[N-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.load_out) begin
      out_r <= v_r;
    end
  end

endmodule

// ----- src/prime_filter_trial_division.sv -----
// ---------------------------------------------------------------------------
// Prime filter by trial division
// Passes prime candidates through and drops all other values.
// ---------------------------------------------------------------------------
// Each candidate beat is tested by trial division with divisors 2, 3, ...
// while divisor squared does not exceed the value; a nonprime value, a
// negative value, zero and one produce no output beat, a prime produces one
// beat carrying the value. One item is in work at a time. Negative values,
// zero and one are dropped in the accept cycle. Every other item is loaded
// when accepted and then takes, per divisor tried, a check, VALUE_WIDTH - 1
// remainder steps and a test. A prime ends with one more check, in which
// the divisor squared exceeds the value. The bit-serial remainder unit
// gives one quotient bit per cycle. A finished prime waits in the output
// register while the next candidate is accepted. If the previous prime is
// still waiting there, the new one holds the block until the output
// register frees.
`timescale 1ns / 1ps
`include "prime_filter_trial_division_macros.svh"

module prime_filter_trial_division #(
  parameter int VALUE_WIDTH = pftd_pkg::PFTD_VALUE_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  pftd_in_if.sink          in_ch,
  pftd_out_if.source       out_ch
);
  import pftd_pkg::*;

  localparam logic [VALUE_WIDTH-2:0] MIN_OUT = (VALUE_WIDTH-1)'(PFTD_MIN_PRIME);

  pftd_cmd_t    cmd;
  pftd_status_t status;
  logic         in_fire;
  logic         in_neg;
  logic [4:0]   cmd_bits;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_neg   = in_ch.candidate[VALUE_WIDTH-1];
  assign cmd_bits = {cmd.load, cmd.start_div, cmd.div_step, cmd.next_div, cmd.load_out};

  pftd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pftd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .candidate   (in_ch.candidate),
    .cmd         (cmd),
    .status      (status),
    .prime_value (out_ch.prime_value)
  );

  `PFTD_ASSERT_NEXT(a_drop_negative, clk, rst_n, in_fire && in_neg, in_ch.ready)
  `PFTD_ASSERT_NEXT(a_busy_after_load, clk, rst_n, in_fire && !status.reject_in, !in_ch.ready)
  `PFTD_ASSERT_SAME(a_out_min, clk, rst_n, out_ch.valid, out_ch.prime_value >= MIN_OUT)
  `PFTD_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd_bits))

endmodule
